// ===== rtl/core/adh_pkg.sv =====
// ----------------------------------------------------------------------------
// adh_pkg
// Types and constants shared by the advertising-data HID detector and its
// channel interfaces.
// ----------------------------------------------------------------------------
package adh_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 16;

    // Field types of interest inside an advertising-data structure.
    localparam logic [BYTE_W-1:0] KIND_UUID16_PART = 8'h02;
    localparam logic [BYTE_W-1:0] KIND_UUID16_ALL  = 8'h03;
    localparam logic [BYTE_W-1:0] KIND_APPEARANCE  = 8'h19;

    localparam logic [WORD_W-1:0] UUID_HID     = 16'h1812;
    localparam logic [9:0]        CATEGORY_HID = 10'd15;

    localparam logic [BYTE_W-1:0] COUNT_MAX = 8'hFF;

    typedef enum logic [3:0] {
        PH_LENGTH  = 4'b0001,
        PH_TYPE    = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_STOPPED = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_adh_in;

    typedef struct packed {
        logic              hid_found;
        logic [WORD_W-1:0] appearance;
    } t_adh_out;

endpackage

// ===== rtl/core/adh_if.sv =====
// ----------------------------------------------------------------------------
// adh_if
// Valid/ready channels of the advertising-data HID detector: one for the
// incoming data bytes and one for the per-stream report.
// ----------------------------------------------------------------------------
interface adh_in_if;
    logic            valid;
    logic            ready;
    adh_pkg::t_adh_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface adh_out_if;
    logic             valid;
    logic             ready;
    adh_pkg::t_adh_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/adv_data_hid_detector.sv =====
// ----------------------------------------------------------------------------
// adv_data_hid_detector
// Walks the length-type-payload structures of a BLE advertising-data stream
// and reports, on its last byte, whether the device announces itself as HID
// and which appearance value it carries.
//
//   channel   direction  payload                      request
//   i_in      sink       data_byte[7:0], last_byte    one advertising byte
//   o_out     source     hid_found, appearance[15:0]  one report per stream
//
// Each byte is captured in an input register and then folded into the parser
// state, so one byte is taken every cycle unless the input side stalls, which
// happens only when a last byte waits behind a report that has not been taken.
// A byte flagged last loads the report register and returns the parser to its
// reset state. Reset (i_rst_n low, synchronous) empties both registers.
// ----------------------------------------------------------------------------
module adv_data_hid_detector (
    input  logic      i_clk,
    input  logic      i_rst_n,
    adh_in_if.sink    i_in,
    adh_out_if.source o_out
);
    import adh_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Parser state.
    t_phase            r_phase,       n_phase;
    logic [BYTE_W-1:0] r_remaining,   n_remaining;
    logic [BYTE_W-1:0] r_kind,        n_kind;
    logic [BYTE_W-1:0] r_count,       n_count;
    logic [BYTE_W-1:0] r_low_hold,    n_low_hold;
    logic              r_pend_hid,    n_pend_hid;
    logic [WORD_W-1:0] r_pend_app,    n_pend_app;
    logic              r_commit_hid,  n_commit_hid;
    logic [WORD_W-1:0] r_commit_app,  n_commit_app;

    // Report register.
    logic              r_out_valid;
    t_adh_out          r_out_payload;

    logic              out_free;
    logic              advance;
    logic              field_done;
    logic              uuid_kind;
    logic [WORD_W-1:0] pair;

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && (!r_in_last || out_free);

    assign i_in.ready    = !r_in_valid || advance;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_payload;

    assign pair      = {r_in_byte, r_low_hold};
    assign uuid_kind = (n_kind == KIND_UUID16_PART) || (n_kind == KIND_UUID16_ALL);

    always_comb begin
        n_phase      = r_phase;
        n_remaining  = r_remaining;
        n_kind       = r_kind;
        n_count      = r_count;
        n_low_hold   = r_low_hold;
        n_pend_hid   = r_pend_hid;
        n_pend_app   = r_pend_app;
        n_commit_hid = r_commit_hid;
        n_commit_app = r_commit_app;
        field_done   = 1'b0;

        if (advance) begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (r_in_byte == '0) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_remaining = r_in_byte;
                        n_phase     = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_kind      = r_in_byte;
                    n_count     = '0;
                    n_pend_hid  = 1'b0;
                    n_pend_app  = '0;
                    n_remaining = r_remaining - 1'b1;
                    if (n_remaining == '0) begin
                        field_done = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (!r_count[0]) begin
                        n_low_hold = r_in_byte;
                    end else begin
                        if (((r_kind == KIND_UUID16_PART) || (r_kind == KIND_UUID16_ALL))
                                && pair == UUID_HID) begin
                            n_pend_hid = 1'b1;
                        end
                        if (r_kind == KIND_APPEARANCE && r_count == 8'd1) begin
                            n_pend_app = pair;
                        end
                    end
                    if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    n_remaining = r_remaining - 1'b1;
                    field_done  = (n_remaining == '0);
                end
                PH_STOPPED: begin
                end
                default: begin
                    n_phase = PH_STOPPED;
                end
            endcase

            // A field that has received its last byte folds into the report.
            if (field_done) begin
                if (uuid_kind) begin
                    if (n_pend_hid) begin
                        n_commit_hid = 1'b1;
                    end
                end else if (n_kind == KIND_APPEARANCE && n_count >= 8'd2) begin
                    n_commit_app = n_pend_app;
                    if (n_pend_app[WORD_W-1:6] == CATEGORY_HID) begin
                        n_commit_hid = 1'b1;
                    end
                end
                n_phase = PH_LENGTH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.payload.data_byte;
            r_in_last <= i_in.payload.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (advance && r_in_last)) begin
            r_phase      <= PH_LENGTH;
            r_remaining  <= '0;
            r_kind       <= '0;
            r_count      <= '0;
            r_low_hold   <= '0;
            r_pend_hid   <= 1'b0;
            r_pend_app   <= '0;
            r_commit_hid <= 1'b0;
            r_commit_app <= '0;
        end else begin
            r_phase      <= n_phase;
            r_remaining  <= n_remaining;
            r_kind       <= n_kind;
            r_count      <= n_count;
            r_low_hold   <= n_low_hold;
            r_pend_hid   <= n_pend_hid;
            r_pend_app   <= n_pend_app;
            r_commit_hid <= n_commit_hid;
            r_commit_app <= n_commit_app;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && r_in_last) begin
            r_out_payload.hid_found  <= n_commit_hid;
            r_out_payload.appearance <= n_commit_app;
        end
    end

endmodule
